>>> hw/rtl/hsfd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
// No dependencies; every other RTL file refers to it by scoped names.
package hsfd_pkg;

	// CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final xor
	localparam logic [7:0] CrcPolyLow = 8'h31;
	localparam logic [7:0] CrcInit    = 8'hFF;

	// status bits in the two lowest bits of a sensor word
	localparam logic [15:0] StatusMask = 16'hFFFC;

	// conversion to hundredths: floor(span * raw / 65535), minus the offset for temperature
	localparam logic [14:0] TempSpan   = 15'd17500;
	localparam logic [14:0] RhSpan     = 15'd10000;
	localparam logic [14:0] TempOffset = 15'd4500;

	// default depth of the command queue between front and back
	localparam int QueueDepthDefault = 4;

	// byte position within a six-byte frame
	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	// one checked word on its way from front to back
	typedef struct packed {
		logic        is_hum;   // 1: humidity word, closes the frame
		logic        ok;       // CRC matched
		logic [15:0] word;     // status bits already cleared
	} cmd_t;

	// one byte through the CRC register, eight shift steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CrcPolyLow) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/humidity_sensor_frame_decoder_core.sv
// Sensor frame decoder: CRC-8 check of temperature and humidity words and
// conversion to hundredths. Accepts one byte per cycle while s_tready is high.
// Path: the humidity CRC beat's command passes through the command queue and stage 1 into the result register.
// Throughput: one byte per cycle; s_tready drops only when the command queue
// fills behind a stalled result register.
// Reset: arst_n clears position, CRC, held values and all valid flags.
module humidity_sensor_frame_decoder_core #(
	parameter int QueueDepth = hsfd_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, rest 0
	output logic [1:0]  m_tuser    // [0] temperature_ok, [1] humidity_ok
);

	logic           beat;
	logic           push, full, pop, not_empty;
	hsfd_pkg::cmd_t push_cmd, pop_cmd;
	logic [14:0]    temperature_centi;
	logic [13:0]    humidity_centi;
	logic           temperature_ok, humidity_ok;

	assign s_tready = !full;
	assign beat     = s_tvalid && s_tready;

	hsfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (beat),
		.data_byte   (s_tdata),
		.frame_start (s_tuser),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	hsfd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	hsfd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (not_empty),
		.cmd               (pop_cmd),
		.cmd_pop           (pop),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temperature_ok    (temperature_ok),
		.humidity_ok       (humidity_ok)
	);

	// pack the result beat
	assign m_tdata = {3'b000, humidity_centi, temperature_centi};
	assign m_tuser = {humidity_ok, temperature_ok};

endmodule

>>> hw/rtl/hsfd_front.sv
// Front part: tracks the byte position, runs the CRC and assembles words.
// Emits one command per checked word toward the queue. Uses hsfd_pkg.
module hsfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	output logic              push,
	output hsfd_pkg::cmd_t    push_cmd
);

	hsfd_pkg::pos_t pos_q, pos_eff, pos_n;
	logic [7:0]     crc_q, crc_n;
	logic [15:0]    word_q, word_n;

	// restart the frame on frame_start
	always_comb begin
		pos_eff = frame_start ? hsfd_pkg::POS_T_HI : pos_q;
	end

	// next position
	always_comb begin
		case (pos_eff)
			hsfd_pkg::POS_T_HI:  pos_n = hsfd_pkg::POS_T_LO;
			hsfd_pkg::POS_T_LO:  pos_n = hsfd_pkg::POS_T_CRC;
			hsfd_pkg::POS_T_CRC: pos_n = hsfd_pkg::POS_H_HI;
			hsfd_pkg::POS_H_HI:  pos_n = hsfd_pkg::POS_H_LO;
			hsfd_pkg::POS_H_LO:  pos_n = hsfd_pkg::POS_H_CRC;
			default:             pos_n = hsfd_pkg::POS_T_HI;
		endcase
	end

	// CRC, word assembly and command per position
	always_comb begin
		crc_n           = crc_q;
		word_n          = word_q;
		push            = 1'b0;
		push_cmd.is_hum = 1'b0;
		push_cmd.ok     = (crc_q == data_byte);
		push_cmd.word   = word_q & hsfd_pkg::StatusMask;
		case (pos_eff)
			hsfd_pkg::POS_T_LO, hsfd_pkg::POS_H_LO: begin
				crc_n  = hsfd_pkg::crc8_byte(crc_q, data_byte);
				word_n = {word_q[15:8], data_byte};
			end
			hsfd_pkg::POS_T_CRC: begin
				crc_n = hsfd_pkg::CrcInit;
				push  = byte_valid;
			end
			hsfd_pkg::POS_H_CRC: begin
				crc_n           = hsfd_pkg::CrcInit;
				push            = byte_valid;
				push_cmd.is_hum = 1'b1;
			end
			default: begin
				crc_n  = hsfd_pkg::crc8_byte(hsfd_pkg::CrcInit, data_byte);
				word_n = {data_byte, 8'h00};
			end
		endcase
	end

	// advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= hsfd_pkg::POS_T_HI;
			crc_q  <= hsfd_pkg::CrcInit;
			word_q <= 16'h0000;
		end else if (byte_valid) begin
			pos_q  <= pos_n;
			crc_q  <= crc_n;
			word_q <= word_n;
		end
	end

endmodule

>>> hw/rtl/hsfd_queue.sv
// Short command queue between front and back, register based.
// Uses hsfd_pkg for the command type.
module hsfd_queue #(
	parameter int Depth = hsfd_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hsfd_pkg::cmd_t    push_cmd,
	output logic              full,
	input  logic              pop,
	output hsfd_pkg::cmd_t    pop_cmd,
	output logic              not_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	hsfd_pkg::cmd_t  entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue popped while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue fill count did not follow a push");

endmodule

>>> hw/rtl/hsfd_back.sv
// Back part: scales checked words to hundredths, holds the last good values
// and drives the result register. Uses hsfd_pkg.
module hsfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  hsfd_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [14:0]       temperature_centi,
	output logic [13:0]       humidity_centi,
	output logic              temperature_ok,
	output logic              humidity_ok
);

	logic        vld_s1, is_hum_s1, ok_s1;
	logic [30:0] prod_s1;
	logic [14:0] span;
	logic        out_free, adv;
	logic [31:0] quo_sum;
	logic [15:0] quo;
	logic [14:0] temp_new;
	logic        frame_temp_ok_q;
	logic [14:0] held_temp_q;
	logic [13:0] held_hum_q;
	logic        m_tvalid_q;

	// stage 1 advances for a temperature word, or when the result register frees
	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = vld_s1 && (!is_hum_s1 || out_free);
	assign cmd_pop  = cmd_valid && (!vld_s1 || adv);
	assign span     = cmd.is_hum ? hsfd_pkg::RhSpan : hsfd_pkg::TempSpan;

	// multiply by the span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_pop) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			is_hum_s1 <= cmd.is_hum;
			ok_s1     <= cmd.ok;
			prod_s1   <= 31'(cmd.word) * 31'(span);
		end
	end

	// divide by 65535: q = (p + (p >> 16) + 1) >> 16 for p below 2^32
	always_comb begin
		quo_sum  = {1'b0, prod_s1} + {17'h0, prod_s1[30:16]} + 32'd1;
		quo      = quo_sum[31:16];
		temp_new = quo[14:0] - hsfd_pkg::TempOffset;
	end

	// hold the last good values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_temp_ok_q <= 1'b0;
			held_temp_q     <= '0;
			held_hum_q      <= '0;
		end else if (adv) begin
			if (!is_hum_s1) begin
				frame_temp_ok_q <= ok_s1;
				if (ok_s1) begin
					held_temp_q <= temp_new;
				end
			end else if (ok_s1) begin
				held_hum_q <= quo[13:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv && is_hum_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_hum_s1) begin
			temperature_centi <= held_temp_q;
			humidity_centi    <= ok_s1 ? quo[13:0] : held_hum_q;
			temperature_ok    <= frame_temp_ok_q;
			humidity_ok       <= ok_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_hum_s1) |-> out_free)
		else $error("result overwritten before it was taken");

endmodule

>>> dv/humidity_sensor_frame_decoder_core_tb.sv
// Self-checking bench for the sensor frame decoder: frame bytes in, one reading per completed frame out.
// Predicts CRC-8 checks and conversions to hundredths; depends only on hsfd_pkg and the core.
module humidity_sensor_frame_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  FrameBytesTarget = 1150;
	localparam int  CycleLimit       = 1000000;
	localparam int  HoldOffCycles    = 300;
	localparam int  MaxPrinted       = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} frame_byte_t;

	typedef struct packed {
		logic [14:0] temp;
		logic [13:0] hum;
		logic        temp_ok;
		logic        hum_ok;
	} reading_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	frame_byte_t pending_bytes[$];
	reading_t    expected_readings[$];

	// decoder state as predicted from the accepted beats
	logic [2:0]  dec_pos      = hsfd_pkg::POS_T_HI;
	logic [7:0]  dec_crc      = hsfd_pkg::CrcInit;
	logic [15:0] dec_word     = 16'h0000;
	logic        dec_temp_ok  = 1'b0;
	logic [14:0] held_temp    = 15'd0;
	logic [13:0] held_hum     = 14'd0;

	bit          in_taken     = 1'b0;
	bit          tx_calm      = 1'b0;
	bit          rx_calm      = 1'b0;
	bit          rx_hold_off  = 1'b0;
	int          tx_gap       = 0;
	int          rx_stall     = 0;
	int          readings_seen = 0;
	int          mismatches   = 0;
	longint      cycle_count  = 0;

	humidity_sensor_frame_decoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] data_byte
		.s_tuser  (s_tuser),   // [0] frame_start
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [14:0] temperature_centi, [28:15] humidity_centi, rest 0
		.m_tuser  (m_tuser)    // [0] temperature_ok, [1] humidity_ok
	);

	always #5 clk = ~clk;

	// bitwise CRC-8, feedback of the top bit against each data bit
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[7] ^ b[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? hsfd_pkg::CrcPolyLow : 8'h00);
		end
		return crc;
	endfunction

	function automatic logic [7:0] word_crc(input logic [15:0] w);
		return crc8_update(crc8_update(hsfd_pkg::CrcInit, w[15:8]), w[7:0]);
	endfunction

	// floor(span * masked_raw / 65535)
	function automatic int to_centi(input logic [15:0] raw, input int span);
		longint w;
		w = longint'(raw & hsfd_pkg::StatusMask);
		return int'((w * span) / 65535);
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(19))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFC;
			3: return 16'h0003;
			4: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic start);
		frame_byte_t fb;
		fb.data  = b;
		fb.start = start;
		pending_bytes.push_back(fb);
	endtask

	task automatic push_word(input logic [15:0] w, input logic crc_good, input logic start);
		logic [7:0] c;
		c = word_crc(w);
		if (!crc_good)
			c = c ^ 8'($urandom_range(1, 255));
		push_byte(w[15:8], start);
		push_byte(w[7:0], 1'b0);
		push_byte(c, 1'b0);
	endtask

	task automatic push_frame(input logic [15:0] tw, input logic tgood,
			input logic [15:0] hw, input logic hgood, input logic start);
		push_word(tw, tgood, start);
		push_word(hw, hgood, 1'b0);
	endtask

	// first n bytes of a well-formed frame, then abandoned
	task automatic push_partial(input logic [15:0] w, input int n);
		logic [7:0] seq[5];
		seq = '{w[15:8], w[7:0], word_crc(w), w[15:8], w[7:0]};
		for (int i = 0; i < n; i++)
			push_byte(seq[i], i == 0);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MaxPrinted)
			$display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// advance the predicted decoder by one accepted beat
	task automatic decode_byte(input logic [7:0] b, input logic start);
		logic [2:0] pos;
		logic       ok;
		reading_t   r;
		pos = dec_pos;
		if (start || pos > hsfd_pkg::POS_H_CRC)
			pos = hsfd_pkg::POS_T_HI;
		case (pos)
			hsfd_pkg::POS_T_HI, hsfd_pkg::POS_H_HI: begin
				dec_crc  = crc8_update(hsfd_pkg::CrcInit, b);
				dec_word = {b, 8'h00};
				dec_pos  = pos + 3'd1;
			end
			hsfd_pkg::POS_T_LO, hsfd_pkg::POS_H_LO: begin
				dec_crc       = crc8_update(dec_crc, b);
				dec_word[7:0] = b;
				dec_pos       = pos + 3'd1;
			end
			hsfd_pkg::POS_T_CRC: begin
				ok          = (dec_crc == b);
				dec_temp_ok = ok;
				if (ok)
					held_temp = 15'(to_centi(dec_word, int'(hsfd_pkg::TempSpan))
						- int'(hsfd_pkg::TempOffset));
				dec_crc = hsfd_pkg::CrcInit;
				dec_pos = hsfd_pkg::POS_H_HI;
			end
			default: begin
				ok = (dec_crc == b);
				if (ok)
					held_hum = 14'(to_centi(dec_word, int'(hsfd_pkg::RhSpan)));
				dec_crc   = hsfd_pkg::CrcInit;
				dec_pos   = hsfd_pkg::POS_T_HI;
				r.temp    = held_temp;
				r.hum     = held_hum;
				r.temp_ok = dec_temp_ok;
				r.hum_ok  = ok;
				expected_readings.push_back(r);
			end
		endcase
	endtask

	// sample both handshakes, predict on input beats, check output beats
	always @(posedge clk) begin
		reading_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken)
			decode_byte(s_tdata, s_tuser);
		if (arst_n && m_tvalid && m_tready) begin
			readings_seen++;
			if (expected_readings.size() == 0) begin
				report_mismatch("reading with none expected", m_tdata, 0);
			end else begin
				want = expected_readings.pop_front();
				if (m_tdata[14:0] !== want.temp)
					report_mismatch("temperature_centi", m_tdata[14:0], want.temp);
				if (m_tdata[28:15] !== want.hum)
					report_mismatch("humidity_centi", m_tdata[28:15], want.hum);
				if (m_tdata[31:29] !== 3'b000)
					report_mismatch("tdata padding", m_tdata[31:29], 0);
				if (m_tuser[0] !== want.temp_ok)
					report_mismatch("temperature_ok", m_tuser[0], want.temp_ok);
				if (m_tuser[1] !== want.hum_ok)
					report_mismatch("humidity_ok", m_tuser[1], want.hum_ok);
			end
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// sender: hold the beat until taken, then advance or idle
	always @(negedge clk) begin
		frame_byte_t fb;
		if (arst_n && (in_taken || !s_tvalid)) begin
			if (in_taken && !tx_calm && !rx_hold_off && $urandom_range(99) < 30)
				tx_gap = gap_len();
			if (tx_gap > 0 || pending_bytes.size() == 0) begin
				s_tvalid <= 1'b0;
				if (tx_gap > 0)
					tx_gap--;
			end else begin
				fb = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= fb.data;
				s_tuser  <= fb.start;
				if ($urandom_range(99) < 2)
					tx_calm = !tx_calm;
			end
		end
	end

	// receiver: random stalls, plus the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold_off) begin
				m_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else if (!rx_calm && $urandom_range(99) < 20) begin
				m_tready <= 1'b0;
				rx_stall = gap_len() - 1;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(199) == 0)
				rx_calm = !rx_calm;
		end
	end

	// hold off the receiver long enough to back up the queue into the input
	initial begin
		while (readings_seen < 20)
			@(posedge clk);
		rx_hold_off = 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		rx_hold_off = 1'b0;
	end

	initial begin
		int r;
		int n;

		// directed frames: extremes, bad CRCs, missing start flag, restart mid-frame
		push_frame(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1);
		push_frame(16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
		push_frame(16'h6666, 1'b0, 16'h8000, 1'b1, 1'b1);
		push_partial(16'h7FFC, 4);
		push_frame(16'h1234, 1'b1, 16'h0003, 1'b1, 1'b1);

		// random: mostly whole frames, some abandoned frames and loose bytes
		while (pending_bytes.size() < FrameBytesTarget) begin
			r = $urandom_range(99);
			if (r < 80) begin
				push_frame(pick_word(), $urandom_range(99) < 85, pick_word(),
					$urandom_range(99) < 85, $urandom_range(9) != 0);
			end else if (r < 92) begin
				push_partial(pick_word(), $urandom_range(1, 5));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom), $urandom_range(3) == 0);
			end
		end

		// reset once, released on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all beats taken, all readings checked, then settle
		while (pending_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
